@@ src/wufc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wufc_pkg
// Shared types and constants of the weighted union-find checker.
// ----------------------------------------------------------------------------
package wufc_pkg;

  // Default number of months; nodes run 0..MONTHS
  localparam int unsigned MONTHS_DEF = 128;
  // Offsets wrap as 32-bit two's complement
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned MONTH_W    = 8;

  localparam logic ACT_CLEAR      = 1'b0;
  localparam logic ACT_CONSTRAINT = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [MONTH_W-1:0]        left_month;
    logic [MONTH_W-1:0]        right_month;
    logic signed [OFF_W-1:0]   total_income;
  } in_t;

  typedef struct packed {
    logic item_ok;
    logic all_ok;
  } out_t;

endpackage

@@ src/wufc_node_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wufc_node_store
// Node memory holding parent index and offset to parent per node. One write
// and one registered read port. A per-node valid bit lets a clear take effect
// at once: an entry never written since the last clear reads as its own root
// with zero offset.
// ----------------------------------------------------------------------------
module wufc_node_store
  import wufc_pkg::*;
#(
  parameter  int unsigned Months  = MONTHS_DEF,
  localparam int unsigned NodeCnt = Months + 1,
  localparam int unsigned IdxW    = $clog2(NodeCnt)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [IdxW-1:0]  rd_parent_o,
  output logic [OFF_W-1:0] rd_offset_o,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [IdxW-1:0]  wr_parent_i,
  input  logic [OFF_W-1:0] wr_offset_i
);

  logic [IdxW+OFF_W-1:0] mem_q [NodeCnt];
  logic [NodeCnt-1:0]    valid_q;
  logic [IdxW+OFF_W-1:0] rdata_q;
  logic                  rvalid_q;
  logic [IdxW-1:0]       raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_parent_i, wr_offset_i};
    end
    if (rd_en_i) begin
      rdata_q  <= mem_q[rd_addr_i];
      rvalid_q <= valid_q[rd_addr_i];
      raddr_q  <= rd_addr_i;
    end
  end

  // Unwritten entry: its own root, zero offset
  assign rd_parent_o = rvalid_q ? rdata_q[IdxW+OFF_W-1:OFF_W] : raddr_q;
  assign rd_offset_o = rvalid_q ? rdata_q[OFF_W-1:0] : '0;

endmodule

@@ src/weighted_union_find_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_union_find_checker
// Checks range-sum constraints for consistency with a weighted union-find.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A clear transaction or one with a
// month out of range goes from idle straight to the done state. A constraint
// walks the parent chain of each of its two nodes and then rewrites that chain,
// all through the single node memory, reading each node visited on the walk and
// writing each node rewritten, before it links the two roots or checks their
// offsets. Path compression keeps depths small. Clear needs no sweep: a valid
// bit per node restores every node at once. The result waits in an output
// register.
// ----------------------------------------------------------------------------
module weighted_union_find_checker
  import wufc_pkg::*;
#(
  parameter int unsigned Months = MONTHS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned NodeCnt = Months + 1;
  localparam int unsigned IdxW    = $clog2(NodeCnt);
  localparam logic [MONTH_W:0] MonthsLim = (MONTH_W+1)'(Months);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_COMP = 6'b000100,
    S_NEXT = 6'b001000,
    S_LINK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]  node_q, node_d;
  logic [IdxW-1:0]  start_q, start_d;
  logic [IdxW-1:0]  root_q, root_d;
  logic [IdxW-1:0]  ra_q, ra_d;
  logic [IdxW-1:0]  b_q, b_d;
  logic [OFF_W-1:0] acc_q, acc_d;
  logic [OFF_W-1:0] tot_q, tot_d;
  logic [OFF_W-1:0] offa_q, offa_d;
  logic [OFF_W-1:0] total_q, total_d;
  logic             find_b_q, find_b_d;
  logic             flag_q, flag_d;
  out_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q;

  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  mem_parent;
  logic [OFF_W-1:0] mem_offset;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [IdxW-1:0]  wr_parent;
  logic [OFF_W-1:0] wr_offset;
  logic             clear;
  logic             out_load;
  logic             ok;

  logic [MONTH_W:0]   left_ext;
  logic [MONTH_W:0]   right_ext;
  logic [MONTH_W-1:0] left_m1;
  logic               out_of_range;

  assign left_ext     = {1'b0, in_data_i.left_month};
  assign right_ext    = {1'b0, in_data_i.right_month};
  assign left_m1      = in_data_i.left_month - MONTH_W'(1);
  assign out_of_range = (in_data_i.left_month == '0) ||
                        ((left_ext - (MONTH_W+1)'(1)) > MonthsLim) ||
                        (right_ext > MonthsLim);

  wufc_node_store #(
    .Months (Months)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_parent_o (mem_parent),
    .rd_offset_o (mem_offset),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_parent_i (wr_parent),
    .wr_offset_i (wr_offset)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    start_d   = start_q;
    root_d    = root_q;
    ra_d      = ra_q;
    b_d       = b_q;
    acc_d     = acc_q;
    tot_d     = tot_q;
    offa_d    = offa_q;
    total_d   = total_q;
    find_b_d  = find_b_q;
    flag_d    = flag_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    rd_addr   = node_q;
    wr_en     = 1'b0;
    wr_addr   = node_q;
    wr_parent = root_q;
    wr_offset = acc_q;
    clear     = 1'b0;
    ok        = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          total_d = in_data_i.total_income;
          b_d     = in_data_i.right_month[IdxW-1:0];
          if (in_data_i.action == ACT_CLEAR) begin
            clear   = 1'b1;
            flag_d  = 1'b1;
            res_d   = '{item_ok: 1'b1, all_ok: 1'b1};
            state_d = S_DONE;
          end else if (out_of_range) begin
            res_d   = '{item_ok: 1'b0, all_ok: flag_q};
            state_d = S_DONE;
          end else begin
            // Start the find on the left node
            rd_en    = 1'b1;
            rd_addr  = left_m1[IdxW-1:0];
            node_d   = left_m1[IdxW-1:0];
            start_d  = left_m1[IdxW-1:0];
            acc_d    = '0;
            find_b_d = 1'b0;
            state_d  = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (mem_parent == node_q) begin
          root_d = node_q;
          tot_d  = acc_q;
          if (node_q == start_q) begin
            state_d = S_NEXT;
          end else begin
            // Rewrite the chain from its start
            rd_en   = 1'b1;
            rd_addr = start_q;
            node_d  = start_q;
            state_d = S_COMP;
          end
        end else begin
          acc_d   = acc_q + mem_offset;
          rd_en   = 1'b1;
          rd_addr = mem_parent;
          node_d  = mem_parent;
        end
      end

      S_COMP: begin
        // Point the node at the root with its offset to the root
        wr_en     = 1'b1;
        wr_addr   = node_q;
        wr_parent = root_q;
        wr_offset = acc_q;
        acc_d     = acc_q - mem_offset;
        if (mem_parent == root_q) begin
          state_d = S_NEXT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mem_parent;
          node_d  = mem_parent;
        end
      end

      S_NEXT: begin
        if (!find_b_q) begin
          ra_d     = root_q;
          offa_d   = tot_q;
          find_b_d = 1'b1;
          start_d  = b_q;
          node_d   = b_q;
          acc_d    = '0;
          rd_en    = 1'b1;
          rd_addr  = b_q;
          state_d  = S_WALK;
        end else begin
          state_d = S_LINK;
        end
      end

      S_LINK: begin
        if (ra_q == root_q) begin
          ok = ((offa_q - tot_q) == total_q);
        end else begin
          // Link the left root under the right root
          wr_en     = 1'b1;
          wr_addr   = ra_q;
          wr_parent = root_q;
          wr_offset = total_q + tot_q - offa_q;
        end
        flag_d  = flag_q & ok;
        res_d   = '{item_ok: ok, all_ok: flag_q & ok};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flag_q      <= 1'b1;
      out_valid_q <= 1'b0;
      find_b_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      find_b_q    <= find_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    start_q <= start_d;
    root_q  <= root_d;
    ra_q    <= ra_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    tot_q   <= tot_d;
    offa_q  <= offa_d;
    total_q <= total_d;
    res_q   <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

endmodule
